// ===== rtl/cutc_pkg.sv =====
package cutc_pkg;

  // Kind of an input beat, carried on in_tuser.
  typedef enum logic [1:0] {
    MODE_STEP    = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_CONNECT = 2'd2
  } mode_t;

  // Register indexes on the configuration port (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_COUNT_MODE = 3'd1,
    REG_THRESHOLD  = 3'd2,
    REG_AUTO_CLEAR = 3'd3,
    REG_HOLD_TIME  = 3'd4
  } reg_idx_t;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef struct packed {
    logic        enable;
    logic        count_mode;
    logic [31:0] count_threshold;
    logic        auto_clear;
    logic [31:0] hold_limit;
  } cutc_cfg_t;

  typedef struct packed {
    logic        status;
    logic [31:0] count_value;
    logic        reached;
    logic        active_out;
  } cutc_res_t;

endpackage

// ===== rtl/cutc_regs.sv =====
module cutc_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cutc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cutc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cutc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  output cutc_pkg::cutc_cfg_t                 cfg
);
  import cutc_pkg::*;

  cutc_cfg_t cfg_r;
  cutc_cfg_t cfg_nxt;
  logic      wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ENABLE:     cfg_nxt.enable          = cfg_pwdata[0];
        REG_COUNT_MODE: cfg_nxt.count_mode      = cfg_pwdata[0];
        REG_THRESHOLD:  cfg_nxt.count_threshold = cfg_pwdata;
        REG_AUTO_CLEAR: cfg_nxt.auto_clear      = cfg_pwdata[0];
        REG_HOLD_TIME:  cfg_nxt.hold_limit      = cfg_pwdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:     cfg_prdata = {31'd0, cfg_r.enable};
      REG_COUNT_MODE: cfg_prdata = {31'd0, cfg_r.count_mode};
      REG_THRESHOLD:  cfg_prdata = cfg_r.count_threshold;
      REG_AUTO_CLEAR: cfg_prdata = {31'd0, cfg_r.auto_clear};
      REG_HOLD_TIME:  cfg_prdata = cfg_r.hold_limit;
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/cutc_core.sv =====
module cutc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [1:0]           mode,
  input  logic                 trig,
  input  logic [31:0]          now,
  input  cutc_pkg::cutc_cfg_t  cfg,
  output cutc_pkg::cutc_res_t  res
);
  import cutc_pkg::*;

  logic [31:0] count_r, count_nxt;
  logic        reached_r, reached_nxt;
  logic        active_r, active_nxt;
  logic [31:0] act_time_r, act_time_nxt;
  logic        last_trig_r, last_trig_nxt;
  logic [31:0] hold_start_r, hold_start_nxt;
  logic        conn_r, conn_nxt;

  logic [31:0] delta;
  logic [31:0] cnt_step;
  logic [31:0] hold_step;
  logic        fire;
  logic        reached_step;
  logic        active_step;
  logic [31:0] act_time_step;
  logic [31:0] cnt_after;
  logic        timeout;
  logic        status;

  // Step path: count update, threshold check, then hold timeout.
  always_comb begin
    delta     = (trig && !last_trig_r) ? 32'd0 : (now - hold_start_r);
    cnt_step  = count_r;
    hold_step = hold_start_r;
    if (!cfg.count_mode) begin
      if (trig && !last_trig_r) begin
        cnt_step = count_r + 32'd1;
      end
    end else if (trig) begin
      cnt_step  = count_r + delta;
      hold_step = now;
    end

    fire          = !reached_r && (cnt_step >= cfg.count_threshold);
    reached_step  = fire ? !cfg.auto_clear : reached_r;
    active_step   = fire | active_r;
    act_time_step = fire ? now : act_time_r;
    cnt_after     = (fire && cfg.auto_clear) ? 32'd0 : cnt_step;
    timeout       = active_step && (cfg.hold_limit != 32'd0) &&
                    ((now - act_time_step) >= cfg.hold_limit);
  end

  always_comb begin
    count_nxt      = count_r;
    reached_nxt    = reached_r;
    active_nxt     = active_r;
    act_time_nxt   = act_time_r;
    last_trig_nxt  = last_trig_r;
    hold_start_nxt = hold_start_r;
    conn_nxt       = conn_r;
    status         = active_r;
    case (mode)
      MODE_STEP: begin
        if (cfg.enable && conn_r) begin
          count_nxt      = cnt_after;
          reached_nxt    = reached_step;
          active_nxt     = active_step & ~timeout;
          act_time_nxt   = act_time_step;
          last_trig_nxt  = trig;
          hold_start_nxt = hold_step;
          status         = active_step & ~timeout;
        end else begin
          status = 1'b0;
        end
      end
      MODE_CLEAR: begin
        count_nxt   = 32'd0;
        reached_nxt = 1'b0;
        active_nxt  = 1'b0;
        status      = 1'b0;
      end
      MODE_CONNECT: begin
        conn_nxt       = 1'b1;
        last_trig_nxt  = trig;
        hold_start_nxt = now;
      end
      default: status = active_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      reached_r    <= 1'b0;
      active_r     <= 1'b0;
      act_time_r   <= '0;
      last_trig_r  <= 1'b0;
      hold_start_r <= '0;
      conn_r       <= 1'b0;
    end else if (go) begin
      count_r      <= count_nxt;
      reached_r    <= reached_nxt;
      active_r     <= active_nxt;
      act_time_r   <= act_time_nxt;
      last_trig_r  <= last_trig_nxt;
      hold_start_r <= hold_start_nxt;
      conn_r       <= conn_nxt;
    end
  end

  assign res.status      = status;
  assign res.count_value = count_nxt;
  assign res.reached     = reached_nxt;
  assign res.active_out  = active_nxt;

endmodule

// ===== rtl/countup_timer_counter_block_top.sv =====
// Count-up counter with threshold and optional hold timeout.
//
// Input channel (in_*): one beat per item. in_tuser carries the kind of the
// item (step, clear or connect); in_tdata carries the trigger level and the
// millisecond timestamp. Output channel (out_*): exactly one result beat per
// input beat, in order, carrying status, the count, and the reached and
// active flags after the item.
//
// A beat accepted by the block lands in the input register; once the output
// register is empty or draining, it is evaluated against the counter state
// and its result is loaded into the output register, which raises out_tvalid.
// While out_tready stays high, one item per cycle is sustained: the state
// update is a single pass of add, compare and subtract logic between the
// two registers.
// When the receiver stalls, the output register holds its beat and the input
// register fills; in_tready then drops until the output drains.
// Synchronous reset clears the configuration registers, the counter state
// and both valid flags. The APB-style port writes registers at 4*index and
// is meant to be written only while no item is in flight.
module countup_timer_counter_block_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] trigger, [32:1] now_ms, [39:33] zero
  input  logic [cutc_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] mode
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] status, [32:1] count_value, [33] reached, [34] active_out, [39:35] zero
  output logic [cutc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cutc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [cutc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [cutc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import cutc_pkg::*;

  cutc_cfg_t   cfg;
  cutc_res_t   res;

  logic        in_valid_r;
  logic [1:0]  in_mode_r;
  logic        in_trig_r;
  logic [31:0] in_now_r;

  logic        out_valid_r;
  cutc_res_t   out_res_r;

  logic        advance;
  logic        in_take;

  // The held item moves on whenever the output register is empty or being
  // drained in this cycle.
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_take   = in_tvalid & in_tready;

  cutc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  cutc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (advance),
    .mode  (in_mode_r),
    .trig  (in_trig_r),
    .now   (in_now_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r <= in_tuser;
      in_trig_r <= in_tdata[0];
      in_now_r  <= in_tdata[32:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.active_out, out_res_r.reached,
                       out_res_r.count_value, out_res_r.status};

endmodule

// ===== bench/cutc_count_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams and the register port, keeps its own copy of the
// counter state, and compares every result beat with the prediction.
module cutc_count_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [cutc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                        in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [cutc_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cutc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [cutc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input  logic [cutc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  input  logic                              cfg_pready,
  output int                                fail_count,
  output int                                outstanding
);
  import cutc_pkg::*;

  // Register copies.
  logic        en_q;
  logic        cmode_q;
  logic [31:0] thresh_q;
  logic        aclr_q;
  logic [31:0] hold_q;

  // Counter state copies.
  logic [31:0] count_q;
  logic        reached_q;
  logic        active_q;
  logic [31:0] act_time_q;
  logic        last_trig_q;
  logic [31:0] hold_start_q;
  logic        linked_q;

  cutc_res_t   pending_results[$];

  function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [31:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_ENABLE:     return {31'd0, en_q};
      REG_COUNT_MODE: return {31'd0, cmode_q};
      REG_THRESHOLD:  return thresh_q;
      REG_AUTO_CLEAR: return {31'd0, aclr_q};
      REG_HOLD_TIME:  return hold_q;
      default:        return 32'd0;
    endcase
  endfunction

  // Advances the counter state by one item and returns the result it causes.
  function automatic cutc_res_t apply_item(logic [1:0] kind, logic trig, logic [31:0] now);
    cutc_res_t r;
    logic      st;
    st = active_q;
    case (kind)
      MODE_STEP: begin
        if (en_q && linked_q) begin
          if (!cmode_q) begin
            if (trig && !last_trig_q) count_q = count_q + 32'd1;
          end else if (trig) begin
            // A fresh press starts timing from now, so it adds nothing.
            if (!last_trig_q) hold_start_q = now;
            count_q = count_q + (now - hold_start_q);
            hold_start_q = now;
          end
          last_trig_q = trig;
          if (!reached_q && count_q >= thresh_q) begin
            reached_q  = 1'b1;
            active_q   = 1'b1;
            act_time_q = now;
            if (aclr_q) begin
              count_q   = 32'd0;
              reached_q = 1'b0;
            end
          end
          if (active_q && hold_q != 32'd0 && (now - act_time_q) >= hold_q)
            active_q = 1'b0;
          st = active_q;
        end else begin
          st = 1'b0;
        end
      end
      MODE_CLEAR: begin
        count_q   = 32'd0;
        reached_q = 1'b0;
        active_q  = 1'b0;
        st        = 1'b0;
      end
      MODE_CONNECT: begin
        linked_q     = 1'b1;
        last_trig_q  = trig;
        hold_start_q = now;
      end
      default: ;
    endcase
    r.status      = st;
    r.count_value = count_q;
    r.reached     = reached_q;
    r.active_out  = active_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    int        errs;
    int        delta;
    cutc_res_t want;
    errs  = 0;
    delta = 0;
    if (!rst_n) begin
      en_q         = 1'b0;
      cmode_q      = 1'b0;
      thresh_q     = 32'd0;
      aclr_q       = 1'b0;
      hold_q       = 32'd0;
      count_q      = 32'd0;
      reached_q    = 1'b0;
      active_q     = 1'b0;
      act_time_q   = 32'd0;
      last_trig_q  = 1'b0;
      hold_start_q = 32'd0;
      linked_q     = 1'b0;
      pending_results.delete();
      outstanding <= 0;
      fail_count  <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (reg_idx_t'(cfg_paddr[4:2]))
            REG_ENABLE:     en_q     = cfg_pwdata[0];
            REG_COUNT_MODE: cmode_q  = cfg_pwdata[0];
            REG_THRESHOLD:  thresh_q = cfg_pwdata;
            REG_AUTO_CLEAR: aclr_q   = cfg_pwdata[0];
            REG_HOLD_TIME:  hold_q   = cfg_pwdata;
            default: ;
          endcase
        end else begin
          errs += field_check("prdata", reg_value(reg_idx_t'(cfg_paddr[4:2])), cfg_prdata);
        end
      end

      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat %0h arrived with no item outstanding", out_tdata);
          errs++;
        end else begin
          want = pending_results.pop_front();
          errs += field_check("status", {31'd0, want.status}, {31'd0, out_tdata[0]});
          errs += field_check("count_value", want.count_value, out_tdata[32:1]);
          errs += field_check("reached", {31'd0, want.reached}, {31'd0, out_tdata[33]});
          errs += field_check("active_out", {31'd0, want.active_out}, {31'd0, out_tdata[34]});
          delta--;
        end
      end

      if (in_tvalid && in_tready) begin
        pending_results.push_back(apply_item(in_tuser, in_tdata[0], in_tdata[32:1]));
        delta++;
      end

      outstanding <= outstanding + delta;
      fail_count  <= fail_count + errs;
    end
  end

endmodule

// ===== bench/countup_timer_counter_block_top_test.sv =====
`timescale 1ns / 100ps

// Top of the bench. It generates clock and reset, drives the item stream and
// the register port, applies random back-pressure on the result stream, and
// gives the verdict from the failure count that the checker reports.
module countup_timer_counter_block_top_test;
  import cutc_pkg::*;

  // The mode code that the block has no use for; it must change nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Watchdog limit on the run length; it leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 78;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [0] trigger, [32:1] now_ms, [39:33] zero
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  // [1:0] mode
  logic [1:0]             in_tuser = MODE_STEP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [0] status, [32:1] count_value, [33] reached, [34] active_out, [39:35] zero
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // Sender pacing: calm_tx turns off gaps for a stretch of items.
  logic        calm_tx = 1'b0;
  int          sent_items = 0;
  // Receiver pacing, owned by the back-pressure block below.
  logic        calm_rx = 1'b0;
  int          stall_left = 0;
  int          rx_cycles = 0;
  // Millisecond clock that the random items carry; it moves forward as items are made.
  logic [31:0] clock_ms;
  logic        trig_lvl = 1'b0;

  countup_timer_counter_block_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  cutc_count_checker count_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // Watchdog. A hang anywhere, including a result that never shows up,
  // ends the run here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Back-pressure on the result stream. Most stalls are a few cycles, a few
  // are long, and every so often a calm stretch keeps tready high so the
  // block runs at full rate. Only one assignment to out_tready per edge.
  always @(posedge clk) begin : rx_pace
    int roll;
    rx_cycles++;
    if (rx_cycles % 256 == 0) calm_rx = ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (!calm_rx && roll < 14) begin
        stall_left = (roll < 2) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Idle cycles to leave before the next item. Mostly none, often a short
  // pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm_tx) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item and returns right after the edge that accepted it.
  // in_tvalid is only lowered when a gap follows, so a back-to-back beat
  // never sees valid dropped and raised within the same time step.
  task automatic send_item(logic [1:0] kind, logic trig, logic [31:0] now);
    int gap;
    sent_items++;
    if (sent_items % 50 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, now, trig};
    do @(posedge clk); while (!in_tready);
  endtask

  // Lets every outstanding result drain, then a few cycles more for the two
  // pipeline registers, so registers are only touched while the block idles.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // access edge. It then drops psel and waits at idle, so back-to-back calls
  // never assign psel twice in the same step.
  task automatic cfg_access(reg_idx_t idx, logic wr, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // One-bit registers get random upper bits, which the block must drop.
  function automatic logic [31:0] flag_word(logic bit_value);
    logic [31:0] w;
    w    = $urandom();
    w[0] = bit_value;
    return w;
  endfunction

  // Writes all five registers and reads each one back; the checker
  // compares every read with its own register copy.
  task automatic apply_settings(logic en, logic cmode, logic [31:0] thresh,
                                logic aclr, logic [31:0] hold);
    int i;
    cfg_access(REG_ENABLE, 1'b1, flag_word(en));
    cfg_access(REG_COUNT_MODE, 1'b1, flag_word(cmode));
    cfg_access(REG_THRESHOLD, 1'b1, thresh);
    cfg_access(REG_AUTO_CLEAR, 1'b1, flag_word(aclr));
    cfg_access(REG_HOLD_TIME, 1'b1, hold);
    for (i = 0; i < 5; i++) cfg_access(reg_idx_t'(i), 1'b0, 32'd0);
  endtask

  // Thresholds favor values that are actually reached: a few edges in
  // event mode, a few thousand milliseconds in hold mode. Extremes and
  // full-range values come up too.
  function automatic logic [31:0] pick_threshold(logic cmode);
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom();
      default: return cmode ? $urandom_range(1, 3000) : $urandom_range(2, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_hold();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'd0;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom();
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  // One random phase. It usually opens with a connect so that steps get
  // past the unconnected check, then runs mostly steps whose trigger level
  // persists for a while and whose time moves forward in small amounts.
  // Clears, reconnects, unused codes, large time jumps and random
  // timestamps are mixed in as noise.
  task automatic run_phase(int n);
    int          k;
    int          roll;
    logic [1:0]  kind;
    logic [31:0] now;
    if ($urandom_range(0, 9) != 0) begin
      trig_lvl = 1'($urandom_range(0, 1));
      send_item(MODE_CONNECT, trig_lvl, clock_ms);
    end
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3)      kind = MODE_CLEAR;
      else if (roll < 6) kind = MODE_CONNECT;
      else if (roll < 8) kind = MODE_UNUSED;
      else               kind = MODE_STEP;
      if ($urandom_range(0, 99) < 30) trig_lvl = ~trig_lvl;
      roll = $urandom_range(0, 99);
      if (roll < 70)      clock_ms = clock_ms + $urandom_range(0, 5);
      else if (roll < 90) clock_ms = clock_ms + $urandom_range(6, 100);
      else if (roll < 97) clock_ms = clock_ms + $urandom_range(0, 65535);
      now = (roll < 97) ? clock_ms : $urandom();
      send_item(kind, trig_lvl, now);
    end
  endtask

  initial begin : stimulus
    int          ph;
    logic        cmode;
    clock_ms = $urandom();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the block is disabled and nothing is connected yet.
    // Steps must leave everything alone, a connect is still recorded, and
    // the unused code changes nothing.
    send_item(MODE_STEP, 1'b1, 32'd0);
    send_item(MODE_CONNECT, 1'b0, 32'd0);
    send_item(MODE_STEP, 1'b1, 32'd1);
    send_item(MODE_UNUSED, 1'b1, 32'hFFFF_FFFF);
    wait_idle();

    // Event mode, threshold three: count rising edges only, latch reached
    // and active on the third, ignore a held level, then clear.
    apply_settings(1'b1, 1'b0, 32'd3, 1'b0, 32'd0);
    send_item(MODE_STEP, 1'b0, 32'd10);
    send_item(MODE_STEP, 1'b1, 32'd11);
    send_item(MODE_STEP, 1'b0, 32'd12);
    send_item(MODE_STEP, 1'b1, 32'd13);
    send_item(MODE_STEP, 1'b0, 32'd14);
    send_item(MODE_STEP, 1'b1, 32'd15);
    send_item(MODE_STEP, 1'b1, 32'd16);
    send_item(MODE_CLEAR, 1'b1, 32'd17);
    send_item(MODE_STEP, 1'b0, 32'd18);
    wait_idle();

    // Hold mode at the extremes: the timestamp wraps through zero, and a
    // near-full elapsed time wraps the count itself back to zero. A fresh
    // press after a release adds nothing.
    apply_settings(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    send_item(MODE_CONNECT, 1'b1, 32'hFFFF_FFF0);
    send_item(MODE_STEP, 1'b1, 32'h0000_0010);
    send_item(MODE_STEP, 1'b1, 32'hFFFF_FFF0);
    send_item(MODE_STEP, 1'b0, 32'd5);
    send_item(MODE_STEP, 1'b1, 32'd100);
    wait_idle();

    // Auto-clear with a short hold: the threshold fires and zeroes the
    // count at once, active holds for just under the timeout and drops
    // exactly when it expires.
    apply_settings(1'b1, 1'b0, 32'd2, 1'b1, 32'd5);
    send_item(MODE_CONNECT, 1'b0, 32'd1000);
    send_item(MODE_STEP, 1'b1, 32'd1001);
    send_item(MODE_STEP, 1'b0, 32'd1002);
    send_item(MODE_STEP, 1'b1, 32'd1003);
    send_item(MODE_STEP, 1'b0, 32'd1007);
    send_item(MODE_STEP, 1'b0, 32'd1008);
    send_item(MODE_STEP, 1'b1, 32'd1009);
    wait_idle();

    // Random phases, each under its own settings. A disabled phase now and
    // then checks that steps stay frozen while clears and connects work.
    for (ph = 0; ph < PHASES; ph++) begin
      cmode = 1'($urandom_range(0, 1));
      apply_settings($urandom_range(0, 9) != 0, cmode, pick_threshold(cmode),
                     1'($urandom_range(0, 1)), pick_hold());
      run_phase(PHASE_ITEMS);
      wait_idle();
    end

    // Everything has drained; leave a few more cycles for any stray beat.
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cutc_pkg.sv
rtl/cutc_regs.sv
rtl/cutc_core.sv
rtl/countup_timer_counter_block_top.sv
bench/cutc_count_checker.sv
bench/countup_timer_counter_block_top_test.sv
